[hw/rtl/ccz_pkg.sv]
// Shared types, widths and constants of the capacitor charge zone controller.
package ccz_pkg;

  localparam int VOLT_W     = 12;
  localparam int PCT_W      = 7;
  localparam int DUTY_W     = 12;
  localparam int IDLE_W     = 6;
  localparam int FLY_W      = 14;
  localparam int ZONE_W     = 3;
  localparam int LIMIT_W    = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  // percent * target and the divide-by-100 reciprocal
  localparam int PROD_W    = PCT_W + VOLT_W;
  localparam int SAT_W     = 14;
  localparam int RECIP_W   = 13;
  localparam int SCALED_W  = SAT_W + RECIP_W;
  localparam int PCT_SHIFT = 19;
  localparam logic [SAT_W-1:0]   PCT_SAT   = 14'd12799;
  localparam logic [RECIP_W-1:0] PCT_RECIP = 13'd5243;

  // cycles after a register write (or reset) before derived limits are valid
  localparam int SETTLE_W = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

  localparam logic [VOLT_W-1:0] BAND_1_V  = 12'd200;
  localparam logic [VOLT_W-1:0] BAND_2_V  = 12'd400;
  localparam logic [VOLT_W-1:0] BAND_3_V  = 12'd600;
  localparam logic [VOLT_W-1:0] BAND_4_V  = 12'd800;
  localparam logic [VOLT_W-1:0] STARTUP_V = 12'd30;

  localparam int DEADZONE_MIN_DEF         = 2;
  localparam int DEADZONE_MAX_DEF         = 20;
  localparam int WINDOW_MIN_DEF           = 5;
  localparam int WINDOW_MAX_DEF           = 50;
  localparam int BRAKE_DISCHARGE_DUTY_DEF = 0;

  localparam logic [VOLT_W-1:0] TARGET_RST   = 12'd0;
  localparam logic [PCT_W-1:0]  DEADZONE_RST = 7'd5;
  localparam logic [PCT_W-1:0]  WINDOW_RST   = 7'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_VOLTAGE    = 4'd0,
    CFG_DEADZONE_PERCENT  = 4'd1,
    CFG_WINDOW_PERCENT    = 4'd2,
    CFG_FLYBACK_LOW_DUTY  = 4'd3,
    CFG_FLYBACK_BAND_STEP = 4'd4,
    CFG_FLYBACK_HIGH_DUTY = 4'd5,
    CFG_FLYBACK_IDLE_DUTY = 4'd6,
    CFG_BRAKE_TOP_DUTY    = 4'd7
  } cfg_idx_t;

  typedef enum logic [ZONE_W-1:0] {
    ZONE_CHARGE           = 3'd0,
    ZONE_SOFT_CHARGE      = 3'd1,
    ZONE_SOFT_DISCHARGE   = 3'd2,
    ZONE_ACTIVE_DISCHARGE = 3'd3,
    ZONE_SHUTDOWN         = 3'd4
  } zone_t;

  typedef struct packed {
    logic [VOLT_W-1:0]  target_voltage;
    logic [DUTY_W-1:0]  flyback_low_duty;
    logic [DUTY_W-1:0]  flyback_band_step;
    logic [DUTY_W-1:0]  flyback_high_duty;
    logic [IDLE_W-1:0]  flyback_idle_duty;
    logic [DUTY_W-1:0]  brake_top_duty;
    logic [LIMIT_W-1:0] err_limit;
    logic [LIMIT_W-1:0] ok_window;
  } ccz_cfg_t;

  typedef struct packed {
    logic [FLY_W-1:0]  flyback_duty;
    logic [DUTY_W-1:0] brake_duty;
    logic              voltage_ok;
    zone_t             zone;
  } ccz_res_t;

endpackage

[hw/rtl/ccz_if.sv]
// Valid/ready channel interfaces: sample input, result output, register writes.
interface ccz_in_if import ccz_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] measured_voltage;
  logic              active;

  modport source (output valid, output measured_voltage, output active, input ready);
  modport sink   (input valid, input measured_voltage, input active, output ready);
endinterface

interface ccz_out_if import ccz_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FLY_W-1:0]  flyback_duty;
  logic [DUTY_W-1:0] brake_duty;
  logic              voltage_ok;
  logic [ZONE_W-1:0] zone;

  modport source (output valid, output flyback_duty, output brake_duty, output voltage_ok,
                  output zone, input ready);
  modport sink   (input valid, input flyback_duty, input brake_duty, input voltage_ok,
                  input zone, output ready);
endinterface

interface ccz_cfg_if import ccz_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/ccz_cfg.sv]
// Configuration registers and the registered error-limit / window derivation.
module ccz_cfg import ccz_pkg::*; #(
  parameter int DEADZONE_MIN = DEADZONE_MIN_DEF,
  parameter int DEADZONE_MAX = DEADZONE_MAX_DEF,
  parameter int WINDOW_MIN   = WINDOW_MIN_DEF,
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ccz_cfg_if.sink   cfg_chan,
  output ccz_cfg_t  cfg,
  output logic      busy
);

  localparam logic [LIMIT_W-1:0] DZ_LO  = LIMIT_W'(DEADZONE_MIN);
  localparam logic [LIMIT_W-1:0] DZ_HI  = LIMIT_W'(DEADZONE_MAX);
  localparam logic [LIMIT_W-1:0] WIN_LO = LIMIT_W'(WINDOW_MIN);
  localparam logic [LIMIT_W-1:0] WIN_HI = LIMIT_W'(WINDOW_MAX);

  logic [VOLT_W-1:0]   target_r;
  logic [PCT_W-1:0]    dz_pct_r;
  logic [PCT_W-1:0]    win_pct_r;
  logic [DUTY_W-1:0]   low_duty_r;
  logic [DUTY_W-1:0]   band_step_r;
  logic [DUTY_W-1:0]   high_duty_r;
  logic [IDLE_W-1:0]   idle_duty_r;
  logic [DUTY_W-1:0]   brake_top_r;
  logic [SETTLE_W-1:0] settle_r;

  logic [PROD_W-1:0]   dz_prod_r;
  logic [PROD_W-1:0]   win_prod_r;
  logic [LIMIT_W-1:0]  lim_r;
  logic [LIMIT_W-1:0]  win_r;

  logic [SAT_W-1:0]    dz_sat;
  logic [SAT_W-1:0]    win_sat;
  logic [SCALED_W-1:0] dz_scaled;
  logic [SCALED_W-1:0] win_scaled;
  logic [LIMIT_W-1:0]  dz_quot;
  logic [LIMIT_W-1:0]  win_quot;
  logic [LIMIT_W-1:0]  lim_nxt;
  logic [LIMIT_W-1:0]  win_nxt;

  function automatic logic [LIMIT_W-1:0] clamp_limit(input logic [LIMIT_W-1:0] q,
                                                      input logic [LIMIT_W-1:0] lo,
                                                      input logic [LIMIT_W-1:0] hi);
    logic [LIMIT_W-1:0] r;
    if (q < lo) begin
      r = lo;
    end else if (q > hi) begin
      r = hi;
    end else begin
      r = q;
    end
    return r;
  endfunction

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= TARGET_RST;
      dz_pct_r    <= DEADZONE_RST;
      win_pct_r   <= WINDOW_RST;
      low_duty_r  <= '0;
      band_step_r <= '0;
      high_duty_r <= '0;
      idle_duty_r <= '0;
      brake_top_r <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_TARGET_VOLTAGE:    target_r    <= cfg_chan.data[VOLT_W-1:0];
        CFG_DEADZONE_PERCENT:  dz_pct_r    <= cfg_chan.data[PCT_W-1:0];
        CFG_WINDOW_PERCENT:    win_pct_r   <= cfg_chan.data[PCT_W-1:0];
        CFG_FLYBACK_LOW_DUTY:  low_duty_r  <= cfg_chan.data[DUTY_W-1:0];
        CFG_FLYBACK_BAND_STEP: band_step_r <= cfg_chan.data[DUTY_W-1:0];
        CFG_FLYBACK_HIGH_DUTY: high_duty_r <= cfg_chan.data[DUTY_W-1:0];
        CFG_FLYBACK_IDLE_DUTY: idle_duty_r <= cfg_chan.data[IDLE_W-1:0];
        CFG_BRAKE_TOP_DUTY:    brake_top_r <= cfg_chan.data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // hold off requests until the two-stage limit derivation has caught up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_CYCLES;
    end else if (cfg_chan.valid) begin
      settle_r <= SETTLE_CYCLES;
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  assign busy = (settle_r != '0);

  // stage 1: percent * target
  always_ff @(posedge clk) begin
    dz_prod_r  <= {{VOLT_W{1'b0}}, dz_pct_r} * {{PCT_W{1'b0}}, target_r};
    win_prod_r <= {{VOLT_W{1'b0}}, win_pct_r} * {{PCT_W{1'b0}}, target_r};
  end

  // stage 2: divide by 100 through the reciprocal, then clamp. Anything at or
  // above 128 after the divide clamps like 127, so saturate first.
  always_comb begin
    dz_sat   = (dz_prod_r > PROD_W'(PCT_SAT)) ? PCT_SAT : dz_prod_r[SAT_W-1:0];
    win_sat  = (win_prod_r > PROD_W'(PCT_SAT)) ? PCT_SAT : win_prod_r[SAT_W-1:0];
    dz_scaled  = {{RECIP_W{1'b0}}, dz_sat} * {{SAT_W{1'b0}}, PCT_RECIP};
    win_scaled = {{RECIP_W{1'b0}}, win_sat} * {{SAT_W{1'b0}}, PCT_RECIP};
    dz_quot  = dz_scaled[PCT_SHIFT +: LIMIT_W];
    win_quot = win_scaled[PCT_SHIFT +: LIMIT_W];
    lim_nxt  = clamp_limit(dz_quot, DZ_LO, DZ_HI);
    win_nxt  = clamp_limit(win_quot, WIN_LO, WIN_HI);
  end

  always_ff @(posedge clk) begin
    lim_r <= lim_nxt;
    win_r <= win_nxt;
  end

  always_comb begin
    cfg.target_voltage    = target_r;
    cfg.flyback_low_duty  = low_duty_r;
    cfg.flyback_band_step = band_step_r;
    cfg.flyback_high_duty = high_duty_r;
    cfg.flyback_idle_duty = idle_duty_r;
    cfg.brake_top_duty    = brake_top_r;
    cfg.err_limit         = lim_r;
    cfg.ok_window         = win_r;
  end

endmodule

[hw/rtl/ccz_core.sv]
// Zone selection, duty computation, charge latch and shutdown tracking.
module ccz_core import ccz_pkg::*; #(
  parameter int BRAKE_DISCHARGE_DUTY = BRAKE_DISCHARGE_DUTY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [VOLT_W-1:0] measured_voltage,
  input  logic              active,
  input  ccz_cfg_t          cfg,
  output ccz_res_t          res,
  output logic              has_result
);

  localparam logic [DUTY_W-1:0] BRAKE_DIS = DUTY_W'(BRAKE_DISCHARGE_DUTY);
  localparam int ERR_W  = VOLT_W + 2;
  localparam int IDLE4_W = IDLE_W + 2;

  logic charge_latch_r;
  logic charge_latch_nxt;
  logic shut_done_r;
  logic shut_done_nxt;

  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W-1:0] aerr;
  logic signed [ERR_W-1:0] lim_s;
  logic signed [ERR_W-1:0] win_s;
  logic signed [ERR_W-1:0] neg_lim;
  logic signed [ERR_W-1:0] neg_2lim;
  logic [FLY_W-1:0]        low14;
  logic [FLY_W-1:0]        step14;
  logic [FLY_W-1:0]        step3;
  logic [FLY_W-1:0]        band_duty;
  logic [IDLE4_W-1:0]      idle1;
  logic [IDLE4_W-1:0]      idle3;
  logic [IDLE4_W-1:0]      idle_duty;

  always_comb begin
    low14  = {2'b00, cfg.flyback_low_duty};
    step14 = {2'b00, cfg.flyback_band_step};
    step3  = step14 + (step14 << 1);
    idle1  = {2'b00, cfg.flyback_idle_duty};
    idle3  = idle1 + (idle1 << 1);

    if (measured_voltage < BAND_1_V) begin
      band_duty = low14;
      idle_duty = idle1;
    end else if (measured_voltage < BAND_2_V) begin
      band_duty = low14 + step14;
      idle_duty = idle1;
    end else if (measured_voltage < BAND_3_V) begin
      band_duty = low14 + (step14 << 1);
      idle_duty = idle1 << 1;
    end else if (measured_voltage < BAND_4_V) begin
      band_duty = low14 + step3;
      idle_duty = idle3;
    end else begin
      band_duty = {2'b00, cfg.flyback_high_duty};
      idle_duty = idle1 << 2;
    end
    // startup: run at the plain idle duty
    if (measured_voltage < STARTUP_V) begin
      band_duty = {{(FLY_W-IDLE_W){1'b0}}, cfg.flyback_idle_duty};
    end
  end

  always_comb begin
    err      = signed'({2'b00, cfg.target_voltage}) - signed'({2'b00, measured_voltage});
    lim_s    = signed'({{(ERR_W-LIMIT_W){1'b0}}, cfg.err_limit});
    win_s    = signed'({{(ERR_W-LIMIT_W){1'b0}}, cfg.ok_window});
    neg_lim  = -lim_s;
    neg_2lim = -(lim_s <<< 1);
    aerr     = (err < 0) ? -err : err;
  end

  always_comb begin
    charge_latch_nxt = charge_latch_r;
    shut_done_nxt    = shut_done_r;
    has_result       = 1'b1;
    res.flyback_duty = '0;
    res.brake_duty   = cfg.brake_top_duty;
    res.voltage_ok   = (aerr < win_s);
    res.zone         = ZONE_SOFT_CHARGE;

    if (!active) begin
      has_result       = !shut_done_r;
      shut_done_nxt    = 1'b1;
      res.brake_duty   = '0;
      res.voltage_ok   = 1'b0;
      res.zone         = ZONE_SHUTDOWN;
    end else begin
      shut_done_nxt = 1'b0;
      if (err >= lim_s) begin
        charge_latch_nxt = 1'b1;
        res.flyback_duty = band_duty;
        res.zone         = ZONE_CHARGE;
      end else if (err <= neg_2lim) begin
        charge_latch_nxt = 1'b0;
        res.brake_duty   = BRAKE_DIS;
        res.zone         = ZONE_ACTIVE_DISCHARGE;
      end else if (err <= neg_lim) begin
        charge_latch_nxt = 1'b0;
        res.zone         = ZONE_SOFT_DISCHARGE;
      end else begin
        // hysteresis: keep idling after a charge phase
        res.flyback_duty = charge_latch_r ? {{(FLY_W-IDLE4_W){1'b0}}, idle_duty} : '0;
        res.zone         = ZONE_SOFT_CHARGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charge_latch_r <= 1'b0;
      shut_done_r    <= 1'b0;
    end else if (fire) begin
      charge_latch_r <= charge_latch_nxt;
      shut_done_r    <= shut_done_nxt;
    end
  end

endmodule

[hw/rtl/cap_charge_zone_controller.sv]
// Top level of the capacitor charge zone controller: input and result registers.
//
//   channel   dir   payload                                        accepted when
//   in_chan   in    measured_voltage[11:0], active                 valid & ready
//   out_chan  out   flyback_duty[13:0], brake_duty[11:0],          valid & ready
//                   voltage_ok, zone[2:0]
//   cfg_chan  in    index[3:0], data[11:0]                         valid & ready
//
// One sample per cycle while results are taken and no register write settles; a result
// passes through the input register, then the result register. A new request is taken
// while a result waits, as long as the input register can move on.
// Reset is synchronous and active low. After reset and after every register write
// requests are held off while the limit multiply/divide stages settle;
// register writes are always taken. A stalled result holds the pipeline behind it.
module cap_charge_zone_controller import ccz_pkg::*; #(
  parameter int DEADZONE_MIN         = DEADZONE_MIN_DEF,
  parameter int DEADZONE_MAX         = DEADZONE_MAX_DEF,
  parameter int WINDOW_MIN           = WINDOW_MIN_DEF,
  parameter int WINDOW_MAX           = WINDOW_MAX_DEF,
  parameter int BRAKE_DISCHARGE_DUTY = BRAKE_DISCHARGE_DUTY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ccz_in_if.sink     in_chan,
  ccz_out_if.source  out_chan,
  ccz_cfg_if.sink    cfg_chan
);

  ccz_cfg_t cfg;
  ccz_res_t res;
  logic     cfg_busy;
  logic     has_result;
  logic     advance;

  logic              s1_valid_r;
  logic [VOLT_W-1:0] s1_voltage_r;
  logic              s1_active_r;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [FLY_W-1:0]  out_fly_r;
  logic [DUTY_W-1:0] out_brake_r;
  logic              out_ok_r;
  logic [ZONE_W-1:0] out_zone_r;

  ccz_cfg #(
    .DEADZONE_MIN (DEADZONE_MIN),
    .DEADZONE_MAX (DEADZONE_MAX),
    .WINDOW_MIN   (WINDOW_MIN),
    .WINDOW_MAX   (WINDOW_MAX)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg),
    .busy     (cfg_busy)
  );

  ccz_core #(
    .BRAKE_DISCHARGE_DUTY (BRAKE_DISCHARGE_DUTY)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (advance),
    .measured_voltage (s1_voltage_r),
    .active           (s1_active_r),
    .cfg              (cfg),
    .res              (res),
    .has_result       (has_result)
  );

  // move the held request into the result register when that slot frees up
  assign advance = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !cfg_busy && !cfg_chan.valid && (!s1_valid_r || advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_voltage_r <= in_chan.measured_voltage;
      s1_active_r  <= in_chan.active;
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = has_result;
    end else begin
      out_valid_nxt = out_valid_r && !out_chan.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_fly_r   <= res.flyback_duty;
      out_brake_r <= res.brake_duty;
      out_ok_r    <= res.voltage_ok;
      out_zone_r  <= res.zone;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.flyback_duty = out_fly_r;
  assign out_chan.brake_duty   = out_brake_r;
  assign out_chan.voltage_ok   = out_ok_r;
  assign out_chan.zone         = out_zone_r;

endmodule

[bench/cap_charge_zone_controller_tb.sv]
// Self-checking bench for the capacitor charge zone controller: zone and duty prediction.
module cap_charge_zone_controller_tb import ccz_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VOLT_MAX      = (1 << VOLT_W) - 1;
  localparam int CFG_REG_COUNT = 8;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 70;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_TAIL   = 6;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_LIMIT  = 10;

  // Predicts a result per active sample and per inactive run; holds results still owed.
  class zone_duty_board;
    logic [VOLT_W-1:0] target_v;
    logic [PCT_W-1:0]  dz_pct;
    logic [PCT_W-1:0]  win_pct;
    logic [DUTY_W-1:0] low_duty;
    logic [DUTY_W-1:0] band_step;
    logic [DUTY_W-1:0] high_duty;
    logic [IDLE_W-1:0] idle_duty;
    logic [DUTY_W-1:0] brake_top;
    bit                charge_latched;
    bit                shut_off;
    ccz_res_t          expected_duties[$];
    int                mismatches;

    function new();
      target_v       = TARGET_RST;
      dz_pct         = DEADZONE_RST;
      win_pct        = WINDOW_RST;
      low_duty       = '0;
      band_step      = '0;
      high_duty      = '0;
      idle_duty      = '0;
      brake_top      = '0;
      charge_latched = 1'b0;
      shut_off       = 1'b0;
      mismatches     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] wdata);
      case (cfg_idx_t'(idx))
        CFG_TARGET_VOLTAGE:    target_v  = wdata[VOLT_W-1:0];
        CFG_DEADZONE_PERCENT:  dz_pct    = wdata[PCT_W-1:0];
        CFG_WINDOW_PERCENT:    win_pct   = wdata[PCT_W-1:0];
        CFG_FLYBACK_LOW_DUTY:  low_duty  = wdata[DUTY_W-1:0];
        CFG_FLYBACK_BAND_STEP: band_step = wdata[DUTY_W-1:0];
        CFG_FLYBACK_HIGH_DUTY: high_duty = wdata[DUTY_W-1:0];
        CFG_FLYBACK_IDLE_DUTY: idle_duty = wdata[IDLE_W-1:0];
        CFG_BRAKE_TOP_DUTY:    brake_top = wdata[DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    // percent of target, truncated, then clamped low bound first
    function int scaled_limit(int pct, int lo, int hi);
      int t;
      t = pct * int'(target_v) / 100;
      if (t < lo)
        t = lo;
      else if (t > hi)
        t = hi;
      return t;
    endfunction

    function void note_sample(logic [VOLT_W-1:0] v, logic act);
      ccz_res_t r;
      int lim;
      int win;
      int err;
      int aerr;
      int band;
      int idle;
      r = '0;
      if (!act) begin
        // one shutdown result, then silence until active again
        if (!shut_off) begin
          shut_off = 1'b1;
          r.zone = ZONE_SHUTDOWN;
          expected_duties.push_back(r);
        end
        return;
      end
      lim = scaled_limit(int'(dz_pct), DEADZONE_MIN_DEF, DEADZONE_MAX_DEF);
      win = scaled_limit(int'(win_pct), WINDOW_MIN_DEF, WINDOW_MAX_DEF);
      err = int'(target_v) - int'(v);
      if (v < BAND_1_V) begin
        band = int'(low_duty);
        idle = int'(idle_duty);
      end else if (v < BAND_2_V) begin
        band = int'(low_duty) + int'(band_step);
        idle = int'(idle_duty);
      end else if (v < BAND_3_V) begin
        band = int'(low_duty) + 2 * int'(band_step);
        idle = 2 * int'(idle_duty);
      end else if (v < BAND_4_V) begin
        band = int'(low_duty) + 3 * int'(band_step);
        idle = 3 * int'(idle_duty);
      end else begin
        band = int'(high_duty);
        idle = 4 * int'(idle_duty);
      end
      // startup override: unscaled idle duty
      if (v < STARTUP_V)
        band = int'(idle_duty);
      if (err >= lim) begin
        charge_latched = 1'b1;
        r.flyback_duty = FLY_W'(band);
        r.brake_duty   = brake_top;
        r.zone         = ZONE_CHARGE;
      end else if (err <= -(lim * 2)) begin
        charge_latched = 1'b0;
        r.flyback_duty = '0;
        r.brake_duty   = DUTY_W'(BRAKE_DISCHARGE_DUTY_DEF);
        r.zone         = ZONE_ACTIVE_DISCHARGE;
      end else if (err <= -lim) begin
        charge_latched = 1'b0;
        r.flyback_duty = '0;
        r.brake_duty   = brake_top;
        r.zone         = ZONE_SOFT_DISCHARGE;
      end else begin
        r.flyback_duty = charge_latched ? FLY_W'(idle) : '0;
        r.brake_duty   = brake_top;
        r.zone         = ZONE_SOFT_CHARGE;
      end
      aerr = (err < 0) ? -err : err;
      r.voltage_ok = (aerr < win);
      shut_off = 1'b0;
      expected_duties.push_back(r);
    endfunction

    function void check_duty(ccz_res_t got);
      ccz_res_t want;
      if (expected_duties.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: flyback %0d brake %0d ok %0b zone %0d",
                   got.flyback_duty, got.brake_duty, got.voltage_ok, got.zone);
        return;
      end
      want = expected_duties.pop_front();
      if (got.flyback_duty !== want.flyback_duty || got.brake_duty !== want.brake_duty ||
          got.voltage_ok !== want.voltage_ok || got.zone !== want.zone) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: flyback %0d/%0d brake %0d/%0d ok %0b/%0b zone %0d/%0d (exp/got)",
                   want.flyback_duty, got.flyback_duty, want.brake_duty, got.brake_duty,
                   want.voltage_ok, got.voltage_ok, want.zone, got.zone);
      end
    endfunction

    function int pending();
      return expected_duties.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ccz_in_if  in_chan ();
  ccz_out_if out_chan ();
  ccz_cfg_if cfg_chan ();

  cap_charge_zone_controller #(
    .DEADZONE_MIN         (DEADZONE_MIN_DEF),
    .DEADZONE_MAX         (DEADZONE_MAX_DEF),
    .WINDOW_MIN           (WINDOW_MIN_DEF),
    .WINDOW_MAX           (WINDOW_MAX_DEF),
    .BRAKE_DISCHARGE_DUTY (BRAKE_DISCHARGE_DUTY_DEF)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  zone_duty_board board = new();

  logic [CFG_DATA_W-1:0] reg_vals [CFG_REG_COUNT];
  bit gaps_on  = 1'b1;
  bit hold_req = 1'b0;
  int hold_left;
  int stall_left;
  int cycle_count;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    ccz_res_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.flyback_duty = out_chan.flyback_duty;
      got.brake_duty   = out_chan.brake_duty;
      got.voltage_ok   = out_chan.voltage_ok;
      got.zone         = zone_t'(out_chan.zone);
      board.check_duty(got);
    end
  end

  // Leaves valid high on return; the caller lowers it when it idles.
  task automatic send_sample(input logic [VOLT_W-1:0] v, input logic act);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid            <= 1'b1;
    in_chan.measured_voltage <= v;
    in_chan.active           <= act;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    board.note_sample(v, act);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] wdata);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= wdata;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    board.write_reg(idx, wdata);
  endtask

  // Write every register, then one index past the list, which must be dropped.
  task automatic apply_settings();
    for (int i = 0; i < CFG_REG_COUNT; i++)
      write_reg(CFG_IDX_W'(i), reg_vals[i]);
    write_reg(CFG_IDX_W'(CFG_REG_COUNT + $urandom_range(0, CFG_REG_COUNT - 1)),
              CFG_DATA_W'($urandom));
    cfg_chan.valid <= 1'b0;
  endtask

  // Hold the sender until every owed result is back, then let the pipe empty.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_TAIL) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_reg(bit is_pct);
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return is_pct ? CFG_DATA_W'(100) : CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Mostly near the target so every zone is hit; some full range and startup.
  function automatic logic [VOLT_W-1:0] rand_voltage(int target);
    int v;
    int off;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom_range(0, VOLT_MAX);
      2: v = $urandom_range(0, 40);
      default: begin
        off = $urandom_range(0, 140);
        v = target + off - 70;
      end
    endcase
    if (v < 0)
      v = 0;
    else if (v > VOLT_MAX)
      v = VOLT_MAX;
    return VOLT_W'(v);
  endfunction

  initial begin
    in_chan.valid            <= 1'b0;
    in_chan.measured_voltage <= '0;
    in_chan.active           <= 1'b0;
    cfg_chan.valid           <= 1'b0;
    cfg_chan.index           <= '0;
    cfg_chan.data            <= '0;
    rst_n                    <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: target 0, so anything at or above the limit of 2 discharges
    send_sample(12'd0, 1'b1);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd0, 1'b0);
    wait_drained();

    // limit clamps to its upper bound, window lands on it exactly
    reg_vals[CFG_TARGET_VOLTAGE]    = 12'd500;
    reg_vals[CFG_DEADZONE_PERCENT]  = 12'd5;
    reg_vals[CFG_WINDOW_PERCENT]    = 12'd10;
    reg_vals[CFG_FLYBACK_LOW_DUTY]  = 12'd100;
    reg_vals[CFG_FLYBACK_BAND_STEP] = 12'd200;
    reg_vals[CFG_FLYBACK_HIGH_DUTY] = 12'd3000;
    reg_vals[CFG_FLYBACK_IDLE_DUTY] = 12'd63;
    reg_vals[CFG_BRAKE_TOP_DUTY]    = 12'd4000;
    apply_settings();
    send_sample(12'd0, 1'b1);
    send_sample(12'd29, 1'b1);
    send_sample(12'd30, 1'b1);
    send_sample(12'd199, 1'b1);
    send_sample(12'd200, 1'b1);
    send_sample(12'd400, 1'b1);
    send_sample(12'd480, 1'b1);
    send_sample(12'd481, 1'b1);
    send_sample(12'd500, 1'b1);
    send_sample(12'd520, 1'b1);
    send_sample(12'd539, 1'b1);
    send_sample(12'd540, 1'b1);
    send_sample(12'd500, 1'b1);
    send_sample(12'd500, 1'b0);
    send_sample(12'd500, 1'b0);
    send_sample(12'd470, 1'b1);
    wait_drained();

    // every field at its top; percents above 100 clamp
    reg_vals[CFG_TARGET_VOLTAGE]    = 12'd4095;
    reg_vals[CFG_DEADZONE_PERCENT]  = 12'd127;
    reg_vals[CFG_WINDOW_PERCENT]    = 12'd127;
    reg_vals[CFG_FLYBACK_LOW_DUTY]  = 12'd4095;
    reg_vals[CFG_FLYBACK_BAND_STEP] = 12'd4095;
    reg_vals[CFG_FLYBACK_HIGH_DUTY] = 12'd4095;
    reg_vals[CFG_FLYBACK_IDLE_DUTY] = 12'd63;
    reg_vals[CFG_BRAKE_TOP_DUTY]    = 12'd4095;
    apply_settings();
    send_sample(12'd799, 1'b1);
    send_sample(12'd800, 1'b1);
    send_sample(12'd600, 1'b1);
    send_sample(12'd0, 1'b1);
    send_sample(12'd4075, 1'b1);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd4095, 1'b0);
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      for (int i = 0; i < CFG_REG_COUNT; i++)
        reg_vals[i] = rand_reg(i == CFG_DEADZONE_PERCENT || i == CFG_WINDOW_PERCENT);
      apply_settings();
      gaps_on = (phase % 3 != 1) && (phase != PHASES - 1);
      // fill the pipe against a stopped receiver
      if (phase == 7)
        hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 4 && n == PHASE_ITEMS / 2)
          wait_drained();
        send_sample(rand_voltage(int'(reg_vals[CFG_TARGET_VOLTAGE])),
                    ($urandom_range(0, 9) != 0));
      end
      wait_drained();
    end

    if (board.mismatches == 0 && board.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
